// ----- rtl/core/lits_pkg.sv -----
// Shared types and constants of the lidar/IMU time synchronizer.
`timescale 1ns / 1ps

package lits_pkg;

  localparam int STAMP_W   = 48;
  localparam int PAYLOAD_W = 64;
  localparam int GUARD_W   = 32;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 32'd100000;

  typedef enum logic [1:0] {
    ACT_IMU,
    ACT_SCAN,
    ACT_PAIR,
    ACT_CLEAR
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED,
    ST_ORDER,
    ST_FULL,
    ST_EMPTY,
    ST_DROPPED,
    ST_WAITING,
    ST_RECORD,
    ST_CLEARED
  } status_t;

  typedef struct packed {
    action_t                action;
    logic [STAMP_W-1:0]     stamp;
    logic [PAYLOAD_W-1:0]   payload;
  } item_t;

  typedef struct packed {
    status_t                status;
    logic                   record_kind;
    logic [STAMP_W-1:0]     record_stamp;
    logic [PAYLOAD_W-1:0]   record_payload;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [STAMP_W-1:0]     stamp;
    logic [PAYLOAD_W-1:0]   payload;
  } entry_t;

endpackage

// ----- rtl/core/lits_chan_if.sv -----
// Valid/ready channel interface carrying one request or result.
`timescale 1ns / 1ps

interface lits_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/lits_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lits_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/lits_cmp.sv -----
// Shared magnitude comparator used by the execute, tail, walk and trim steps of the sequencer.
`timescale 1ns / 1ps

module lits_cmp #(
  parameter int W = 49
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt
);
  assign lt = (a < b);
endmodule

// ----- rtl/core/lidar_imu_time_synchronizer_unit.sv -----
// Top level of the lidar/IMU time synchronizer: queues, sequencer and result register.
// Push, clear, empty and stale-scan requests are registered in S_IDLE and answered from S_EXEC.
// Other pair requests pass S_TAIL_RD and S_TAIL, then S_WALK_RD and S_WALK for each IMU record,
// set by the single read port of the IMU RAM, then S_TRIM_RD and S_TRIM per removed entry plus one.
// Reset clears pointers, counts, last stamps and seen flags and loads the guard with 100000.
// Queue storage is not cleared; only occupied entries affect results.
`timescale 1ns / 1ps

module lidar_imu_time_synchronizer_unit
  import lits_pkg::*;
#(
  parameter int IMU_DEPTH  = 32,
  parameter int SCAN_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  lits_chan_if.sink          item,
  lits_chan_if.source        result,
  input  logic               cfg_we,
  input  logic [GUARD_W-1:0] cfg_wdata
);
  localparam int IMU_AW  = $clog2(IMU_DEPTH);
  localparam int SCAN_AW = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
  localparam int IMU_CW  = $clog2(IMU_DEPTH + 1);
  localparam int SCAN_CW = $clog2(SCAN_DEPTH + 1);
  localparam int IMU_SW  = IMU_CW + 1;
  localparam int SCAN_SW = SCAN_CW + 1;
  localparam int CMP_W   = STAMP_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TAIL_RD,
    S_TAIL,
    S_WALK_RD,
    S_WALK,
    S_TRIM_RD,
    S_TRIM
  } state_t;

  state_t               state;
  action_t              act;
  logic [STAMP_W-1:0]   in_stamp;
  logic [PAYLOAD_W-1:0] in_payload;
  logic [GUARD_W-1:0]   guard;
  logic [IMU_AW-1:0]    imu_head;
  logic [IMU_CW-1:0]    imu_count;
  logic [SCAN_AW-1:0]   scan_head;
  logic [SCAN_CW-1:0]   scan_count;
  logic [STAMP_W-1:0]   last_imu;
  logic                 imu_seen;
  logic [STAMP_W-1:0]   last_scan;
  logic                 scan_seen;
  logic [IMU_AW-1:0]    imu_raddr;
  logic [IMU_CW-1:0]    walk_idx;
  logic [CMP_W-1:0]     win_end;
  logic                 out_valid;
  result_t              out_data;

  logic [IMU_SW-1:0]    imu_tail_sum;
  logic [IMU_SW-1:0]    imu_last_sum;
  logic [IMU_AW-1:0]    imu_tail_slot;
  logic [IMU_AW-1:0]    imu_last_slot;
  logic [SCAN_SW-1:0]   scan_tail_sum;
  logic [SCAN_AW-1:0]   scan_tail_slot;
  logic [IMU_AW-1:0]    imu_ram_raddr;
  entry_t               imu_rd;
  entry_t               scan_rd;
  logic                 imu_full;
  logic                 scan_full;
  logic                 imu_push_ok;
  logic                 scan_push_ok;
  logic                 walk_done;
  logic                 out_free;
  logic                 pair_go;
  logic                 out_load;
  logic [CMP_W-1:0]     cmp_a;
  logic [CMP_W-1:0]     cmp_b;
  logic                 cmp_lt;

  function automatic logic [IMU_AW-1:0] imu_inc(input logic [IMU_AW-1:0] x);
    imu_inc = (x == IMU_AW'(IMU_DEPTH - 1)) ? '0 : x + IMU_AW'(1);
  endfunction

  function automatic logic [SCAN_AW-1:0] scan_inc(input logic [SCAN_AW-1:0] x);
    scan_inc = (x == SCAN_AW'(SCAN_DEPTH - 1)) ? '0 : x + SCAN_AW'(1);
  endfunction

  function automatic result_t single_rsp(input status_t s);
    result_t r;
    r.status         = s;
    r.record_kind    = 1'b0;
    r.record_stamp   = '0;
    r.record_payload = '0;
    r.last           = 1'b1;
    single_rsp = r;
  endfunction

  function automatic result_t record_rsp(input logic kind, input entry_t e, input logic fin);
    result_t r;
    r.status         = ST_RECORD;
    r.record_kind    = kind;
    r.record_stamp   = e.stamp;
    r.record_payload = e.payload;
    r.last           = fin;
    record_rsp = r;
  endfunction

  // Ring slot arithmetic; depths need not be powers of two.
  always_comb begin
    imu_tail_sum  = IMU_SW'(imu_head) + IMU_SW'(imu_count);
    imu_last_sum  = imu_tail_sum - IMU_SW'(1);
    imu_tail_slot = (imu_tail_sum >= IMU_SW'(IMU_DEPTH)) ?
                    IMU_AW'(imu_tail_sum - IMU_SW'(IMU_DEPTH)) : IMU_AW'(imu_tail_sum);
    imu_last_slot = (imu_last_sum >= IMU_SW'(IMU_DEPTH)) ?
                    IMU_AW'(imu_last_sum - IMU_SW'(IMU_DEPTH)) : IMU_AW'(imu_last_sum);
    scan_tail_sum  = SCAN_SW'(scan_head) + SCAN_SW'(scan_count);
    scan_tail_slot = (scan_tail_sum >= SCAN_SW'(SCAN_DEPTH)) ?
                     SCAN_AW'(scan_tail_sum - SCAN_SW'(SCAN_DEPTH)) : SCAN_AW'(scan_tail_sum);
  end

  // While idle the read port follows the head, so the oldest sample is ready
  // in the first cycle of a pair request.
  assign imu_ram_raddr = (state == S_IDLE) ? imu_head : imu_raddr;

  lits_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (IMU_DEPTH)
  ) u_imu_ram (
    .clk   (clk),
    .we    (imu_push_ok),
    .waddr (imu_tail_slot),
    .wdata ({in_stamp, in_payload}),
    .raddr (imu_ram_raddr),
    .rdata (imu_rd)
  );

  lits_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SCAN_DEPTH)
  ) u_scan_ram (
    .clk   (clk),
    .we    (scan_push_ok),
    .waddr (scan_tail_slot),
    .wdata ({in_stamp, in_payload}),
    .raddr (scan_head),
    .rdata (scan_rd)
  );

  // Operand selection for the shared comparator, one compare per step.
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state)
      S_EXEC: begin
        case (act)
          ACT_IMU: begin
            cmp_a = {1'b0, in_stamp};
            cmp_b = {1'b0, last_imu};
          end
          ACT_SCAN: begin
            cmp_a = {1'b0, in_stamp};
            cmp_b = {1'b0, last_scan};
          end
          default: begin
            cmp_a = {1'b0, scan_rd.stamp};
            cmp_b = {1'b0, imu_rd.stamp};
          end
        endcase
      end
      S_TAIL, S_WALK: begin
        cmp_a = {1'b0, imu_rd.stamp};
        cmp_b = win_end;
      end
      S_TRIM: begin
        cmp_a = win_end;
        cmp_b = {1'b0, imu_rd.stamp};
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  lits_cmp #(
    .W (CMP_W)
  ) u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign out_free     = !out_valid || result.ready;
  assign imu_full     = (imu_count == IMU_CW'(IMU_DEPTH));
  assign scan_full    = (scan_count == SCAN_CW'(SCAN_DEPTH));
  assign imu_push_ok  = (state == S_EXEC) && out_free && (act == ACT_IMU) &&
                        !(imu_seen && cmp_lt) && !imu_full;
  assign scan_push_ok = (state == S_EXEC) && out_free && (act == ACT_SCAN) &&
                        !(scan_seen && cmp_lt) && !scan_full;
  assign pair_go      = (act == ACT_PAIR) && (imu_count != '0) && (scan_count != '0) &&
                        !cmp_lt;
  assign walk_done    = !cmp_lt || ((walk_idx + IMU_CW'(1)) == imu_count);

  // The result register is loaded at every output step except the start of a pair walk.
  always_comb begin
    out_load = 1'b0;
    if (out_free) begin
      case (state)
        S_EXEC:         out_load = !pair_go;
        S_TAIL, S_WALK: out_load = 1'b1;
        default:        out_load = 1'b0;
      endcase
    end
  end

  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      guard      <= GUARD_RESET;
      imu_head   <= '0;
      imu_count  <= '0;
      scan_head  <= '0;
      scan_count <= '0;
      last_imu   <= '0;
      imu_seen   <= 1'b0;
      last_scan  <= '0;
      scan_seen  <= 1'b0;
    end else begin
      if (cfg_we) begin
        guard <= cfg_wdata;
      end
      out_valid <= out_load || (out_valid && !result.ready);
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            act        <= item.data.action;
            in_stamp   <= item.data.stamp;
            in_payload <= item.data.payload;
            imu_raddr  <= imu_head;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= pair_go ? S_TAIL_RD : S_IDLE;
            case (act)
              ACT_IMU: begin
                if (imu_seen && cmp_lt) begin
                  out_data <= single_rsp(ST_ORDER);
                end else if (imu_full) begin
                  out_data <= single_rsp(ST_FULL);
                end else begin
                  imu_count <= imu_count + IMU_CW'(1);
                  last_imu  <= in_stamp;
                  imu_seen  <= 1'b1;
                  out_data  <= single_rsp(ST_ACCEPTED);
                end
              end
              ACT_SCAN: begin
                if (scan_seen && cmp_lt) begin
                  out_data <= single_rsp(ST_ORDER);
                end else if (scan_full) begin
                  out_data <= single_rsp(ST_FULL);
                end else begin
                  scan_count <= scan_count + SCAN_CW'(1);
                  last_scan  <= in_stamp;
                  scan_seen  <= 1'b1;
                  out_data   <= single_rsp(ST_ACCEPTED);
                end
              end
              ACT_PAIR: begin
                win_end <= {1'b0, scan_rd.stamp} + CMP_W'(guard);
                if (imu_count == '0 || scan_count == '0) begin
                  out_data <= single_rsp(ST_EMPTY);
                end else if (cmp_lt) begin
                  // The oldest IMU sample is already past the scan.
                  scan_head  <= scan_inc(scan_head);
                  scan_count <= scan_count - SCAN_CW'(1);
                  out_data   <= single_rsp(ST_DROPPED);
                end else begin
                  imu_raddr <= imu_last_slot;
                end
              end
              default: begin
                imu_head   <= '0;
                imu_count  <= '0;
                scan_head  <= '0;
                scan_count <= '0;
                out_data   <= single_rsp(ST_CLEARED);
              end
            endcase
          end
        end
        S_TAIL_RD: begin
          state <= S_TAIL;
        end
        S_TAIL: begin
          if (out_free) begin
            if (cmp_lt) begin
              out_data <= single_rsp(ST_WAITING);
              state    <= S_IDLE;
            end else begin
              out_data   <= record_rsp(1'b0, scan_rd, 1'b0);
              scan_head  <= scan_inc(scan_head);
              scan_count <= scan_count - SCAN_CW'(1);
              imu_raddr  <= imu_head;
              walk_idx   <= '0;
              state      <= S_WALK_RD;
            end
          end
        end
        S_WALK_RD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (out_free) begin
            out_data <= record_rsp(1'b1, imu_rd, walk_done);
            if (walk_done) begin
              imu_raddr <= imu_inc(imu_head);
              state     <= S_TRIM_RD;
            end else begin
              walk_idx  <= walk_idx + IMU_CW'(1);
              imu_raddr <= imu_inc(imu_raddr);
              state     <= S_WALK_RD;
            end
          end
        end
        S_TRIM_RD: begin
          state <= S_TRIM;
        end
        S_TRIM: begin
          // Drop the head while the next sample is still inside the window.
          if (imu_count > IMU_CW'(1) && !cmp_lt) begin
            imu_head  <= imu_inc(imu_head);
            imu_count <= imu_count - IMU_CW'(1);
            imu_raddr <= imu_inc(imu_raddr);
            state     <= S_TRIM_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ----- rtl/core/lits_checker.sv -----
// Port-level assertions for the lidar/IMU time synchronizer and their bind.
`timescale 1ns / 1ps

module lits_checker
  import lits_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // A request is worked on alone, so the input closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after a request was accepted");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_RECORD |->
      out_data.last && !out_data.record_kind &&
      out_data.record_stamp == '0 && out_data.record_payload == '0)
    else $error("single result not marked last or carries record fields");

  // The scan record always has IMU records after it.
  a_scan_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_RECORD && !out_data.record_kind |-> !out_data.last)
    else $error("scan record marked last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind lidar_imu_time_synchronizer_unit lits_checker u_lits_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);
